// ===== rtl/knn_vote_top_three_macros.svh =====
// Assertion macros for the nearest-neighbour vote block.
// Used by the top level; relies on i_clk and i_rst_n in the including scope.
`ifndef KNN_VOTE_TOP_THREE_MACROS_SVH
`define KNN_VOTE_TOP_THREE_MACROS_SVH
`ifndef SYNTHESIS
`define KVT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define KVT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KVT_ASSERT_IMPL(lbl, ante, cons)
`define KVT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/kvt_pkg.sv =====
// Shared constants, types and state codes for the nearest-neighbour vote block.
// No dependencies.
package kvt_pkg;
    localparam int MAX_SAMPLES = 1024;
    localparam int NUM_CLASSES = 128;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int CLS_W       = $clog2(NUM_CLASSES);
    localparam int CLS_CNT_W   = CLS_W + 1;
    localparam int SCORE_W     = 20;
    localparam int CLASS_W     = 7;
    localparam int VOTE_W      = 7;
    localparam int K_W         = 7;
    localparam int SMP_W       = SCORE_W + CLASS_W;

    localparam logic [K_W-1:0] K_RESET = K_W'(40);

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN,
        S_VOTE_RD,
        S_VOTE_WR,
        S_RANK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic               valid;
        logic [CLASS_W-1:0] cls;
        logic [VOTE_W-1:0]  votes;
    } t_rank_ctl;

    typedef struct packed {
        logic [CLASS_W-1:0] c1;
        logic [CLASS_W-1:0] c2;
        logic [CLASS_W-1:0] c3;
        logic [VOTE_W-1:0]  v1;
        logic [VOTE_W-1:0]  v2;
        logic [VOTE_W-1:0]  v3;
    } t_top3;
endpackage

// ===== rtl/kvt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/kvt_rank.sv =====
// Running top-three ranking over a stream of (class, votes) words.
// Depends on kvt_pkg.
module kvt_rank (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  kvt_pkg::t_rank_ctl i_ctl,
    output kvt_pkg::t_top3    o_top
);
    import kvt_pkg::*;

    logic [2:0]         r_ok;
    logic [CLASS_W-1:0] r_c [3];
    logic [VOTE_W-1:0]  r_v [3];
    logic               ge1, ge2, ge3;

    // later ids win ties, so >= moves the incoming word ahead
    assign ge1 = !r_ok[0] || (i_ctl.votes >= r_v[0]);
    assign ge2 = !r_ok[1] || (i_ctl.votes >= r_v[1]);
    assign ge3 = !r_ok[2] || (i_ctl.votes >= r_v[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_ok <= '0;
        end else if (i_ctl.valid) begin
            priority if (ge1) begin
                r_ok <= {r_ok[1], r_ok[0], 1'b1};
            end else if (ge2) begin
                r_ok <= {r_ok[1], 1'b1, r_ok[0]};
            end else if (ge3) begin
                r_ok <= {1'b1, r_ok[1], r_ok[0]};
            end else begin
                r_ok <= r_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            priority if (ge1) begin
                r_c[2] <= r_c[1]; r_v[2] <= r_v[1];
                r_c[1] <= r_c[0]; r_v[1] <= r_v[0];
                r_c[0] <= i_ctl.cls; r_v[0] <= i_ctl.votes;
            end else if (ge2) begin
                r_c[2] <= r_c[1]; r_v[2] <= r_v[1];
                r_c[1] <= i_ctl.cls; r_v[1] <= i_ctl.votes;
            end else if (ge3) begin
                r_c[2] <= i_ctl.cls; r_v[2] <= i_ctl.votes;
            end else begin
                r_c[2] <= r_c[2]; r_v[2] <= r_v[2];
            end
        end
    end

    assign o_top = '{c1: r_c[0], c2: r_c[1], c3: r_c[2],
                     v1: r_v[0], v2: r_v[1], v3: r_v[2]};
endmodule

// ===== rtl/knn_vote_top_three.sv =====
// Nearest-neighbour vote block: sample store, selection sequencer, vote table.
// Depends on kvt_pkg, kvt_ram, kvt_rank and knn_vote_top_three_macros.svh.
//
// A query with N loaded samples and P = min(K, N) picks runs as follows: the vote
// table is wiped, each pick is one pass over the single read port of the sample
// memory plus a vote update, and ranking reads the vote table once and hands off
// the result.
// New input is stalled while a query runs; loads are taken while a result waits.
module knn_vote_top_three (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_op,
    input  logic [kvt_pkg::SCORE_W-1:0]   i_sample_score,
    input  logic [kvt_pkg::CLASS_W-1:0]   i_sample_class,
    input  logic [kvt_pkg::SCORE_W-1:0]   i_query_score,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [kvt_pkg::CLASS_W-1:0]   o_first_class,
    output logic [kvt_pkg::CLASS_W-1:0]   o_second_class,
    output logic [kvt_pkg::CLASS_W-1:0]   o_third_class,
    output logic [kvt_pkg::VOTE_W-1:0]    o_first_votes,
    output logic [kvt_pkg::VOTE_W-1:0]    o_second_votes,
    output logic [kvt_pkg::VOTE_W-1:0]    o_third_votes,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [kvt_pkg::K_W-1:0]       i_cfg_data
);
    import kvt_pkg::*;
    `include "knn_vote_top_three_macros.svh"

    t_state r_state, n_state;

    logic [K_W-1:0]       r_k;
    logic [CNT_W-1:0]     r_count;
    logic [SCORE_W-1:0]   r_q;
    logic [K_W-1:0]       r_k_left;
    logic [CNT_W-1:0]     r_addr;
    logic [CLS_CNT_W-1:0] r_cls;

    logic                 r_p1_v;
    logic [ADDR_W-1:0]    r_p1_i;
    logic                 r_p2_v;
    logic [ADDR_W-1:0]    r_p2_i;
    logic [SCORE_W-1:0]   r_p2_d;
    logic [CLASS_W-1:0]   r_p2_c;

    logic                 r_best_v;
    logic [ADDR_W-1:0]    r_best_i;
    logic [SCORE_W-1:0]   r_best_d;
    logic [CLASS_W-1:0]   r_best_c;
    logic                 r_last_v;
    logic [ADDR_W-1:0]    r_last_i;
    logic [SCORE_W-1:0]   r_last_d;

    logic                 r_rk_v;
    logic [CLS_W-1:0]     r_rk_c;

    logic                 r_out_valid;
    t_top3                r_out;

    logic                 in_acc, out_free, issue, pass_done, rank_issue, rank_done;
    logic                 clear_done, gt_last, lt_best;
    logic [SMP_W-1:0]     smp_rdata;
    logic [SCORE_W-1:0]   smp_score, smp_dist;
    logic [CLASS_W-1:0]   smp_class;
    logic                 smp_we;
    logic                 vote_we;
    logic [CLS_W-1:0]     vote_waddr, vote_raddr;
    logic [VOTE_W-1:0]    vote_wdata, vote_rdata;
    logic [CNT_W-1:0]     k_ext;
    t_rank_ctl            rank_ctl;
    t_top3                top;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign issue      = (r_state == S_SCAN) && (r_addr < r_count);
    assign pass_done  = (r_state == S_SCAN) && !(r_addr < r_count) && !r_p1_v && !r_p2_v;
    assign clear_done = (r_cls == CLS_CNT_W'(NUM_CLASSES));
    assign rank_issue = (r_state == S_RANK) && !clear_done;
    assign rank_done  = clear_done && !r_rk_v;
    assign k_ext      = CNT_W'(r_k);

    assign smp_score = smp_rdata[SCORE_W-1:0];
    assign smp_class = smp_rdata[SMP_W-1:SCORE_W];
    assign smp_dist  = (smp_score > r_q) ? (smp_score - r_q) : (r_q - smp_score);

    assign gt_last = !r_last_v || (r_p2_d > r_last_d) ||
                     ((r_p2_d == r_last_d) && (r_p2_i > r_last_i));
    assign lt_best = !r_best_v || (r_p2_d < r_best_d);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (in_acc && i_op == OP_QUERY) n_state = S_CLEAR;
            S_CLEAR:   if (clear_done) n_state = (r_k_left == '0) ? S_RANK : S_SCAN;
            S_SCAN:    if (pass_done) n_state = S_VOTE_RD;
            S_VOTE_RD: n_state = S_VOTE_WR;
            S_VOTE_WR: n_state = (r_k_left == K_W'(1)) ? S_RANK : S_SCAN;
            S_RANK:    if (rank_done) n_state = S_OUT;
            S_OUT:     if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        o_cfg_ready = 1'b1;
        smp_we     = in_acc && (i_op == OP_LOAD) && (r_count < CNT_W'(MAX_SAMPLES));
        vote_we    = 1'b0;
        vote_waddr = r_cls[CLS_W-1:0];
        vote_wdata = '0;
        vote_raddr = r_best_c[CLS_W-1:0];
        unique case (r_state)
            S_CLEAR:   vote_we = !clear_done;
            S_VOTE_WR: begin
                vote_we    = 1'b1;
                vote_waddr = r_best_c[CLS_W-1:0];
                vote_wdata = vote_rdata + VOTE_W'(1);
            end
            S_RANK:    vote_raddr = r_cls[CLS_W-1:0];
            default:   vote_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= K_RESET;
            r_count     <= '0;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_rk_v      <= 1'b0;
            r_best_v    <= 1'b0;
            r_last_v    <= 1'b0;
            r_out_valid <= 1'b0;
            r_cls       <= '0;
            r_addr      <= '0;
            r_k_left    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_k <= i_cfg_data;
            if (in_acc && i_op == OP_CLEAR) r_count <= '0;
            if (smp_we) r_count <= r_count + CNT_W'(1);

            if (in_acc && i_op == OP_QUERY) begin
                r_cls    <= '0;
                r_last_v <= 1'b0;
                r_k_left <= (k_ext < r_count) ? r_k : K_W'(r_count);
            end else if ((r_state == S_CLEAR && clear_done) || rank_issue ||
                         (r_state == S_CLEAR)) begin
                r_cls <= clear_done ? '0 : r_cls + CLS_CNT_W'(1);
            end

            // open a fresh pass
            if (n_state == S_SCAN && r_state != S_SCAN) begin
                r_addr   <= '0;
                r_best_v <= 1'b0;
            end else if (issue) begin
                r_addr <= r_addr + CNT_W'(1);
            end

            r_p1_v <= issue;
            r_p2_v <= r_p1_v;
            if (r_p2_v && gt_last && lt_best) r_best_v <= 1'b1;

            if (r_state == S_VOTE_WR) begin
                r_last_v <= 1'b1;
                r_k_left <= r_k_left - K_W'(1);
            end

            r_rk_v <= rank_issue;

            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_op == OP_QUERY) r_q <= i_query_score;
        r_p1_i <= r_addr[ADDR_W-1:0];
        r_p2_i <= r_p1_i;
        r_p2_d <= smp_dist;
        r_p2_c <= smp_class;
        if (r_p2_v && gt_last && lt_best) begin
            r_best_i <= r_p2_i;
            r_best_d <= r_p2_d;
            r_best_c <= r_p2_c;
        end
        if (r_state == S_VOTE_WR) begin
            r_last_i <= r_best_i;
            r_last_d <= r_best_d;
        end
        r_rk_c <= r_cls[CLS_W-1:0];
        if (r_state == S_OUT && out_free) r_out <= top;
    end

    kvt_ram #(.WIDTH(SMP_W), .DEPTH(MAX_SAMPLES)) u_smp_ram (
        .i_clk   (i_clk),
        .i_we    (smp_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata ({i_sample_class, i_sample_score}),
        .i_raddr (r_addr[ADDR_W-1:0]),
        .o_rdata (smp_rdata)
    );

    kvt_ram #(.WIDTH(VOTE_W), .DEPTH(NUM_CLASSES)) u_vote_ram (
        .i_clk   (i_clk),
        .i_we    (vote_we),
        .i_waddr (vote_waddr),
        .i_wdata (vote_wdata),
        .i_raddr (vote_raddr),
        .o_rdata (vote_rdata)
    );

    assign rank_ctl = '{valid: r_rk_v, cls: CLASS_W'(r_rk_c), votes: vote_rdata};

    kvt_rank u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc && i_op == OP_QUERY),
        .i_ctl   (rank_ctl),
        .o_top   (top)
    );

    assign o_out_valid    = r_out_valid;
    assign o_first_class  = r_out.c1;
    assign o_second_class = r_out.c2;
    assign o_third_class  = r_out.c3;
    assign o_first_votes  = r_out.v1;
    assign o_second_votes = r_out.v2;
    assign o_third_votes  = r_out.v3;

    `KVT_ASSERT_IMPL(a_accept_idle, in_acc, r_state == S_IDLE)
    `KVT_ASSERT_IMPL(a_votes_order, o_out_valid,
        (o_first_votes >= o_second_votes) && (o_second_votes >= o_third_votes))
    `KVT_ASSERT_IMPL(a_classes_differ, o_out_valid,
        (o_first_class != o_second_class) && (o_first_class != o_third_class) &&
        (o_second_class != o_third_class))
    `KVT_ASSERT_NEXT(a_pass_has_best, pass_done, r_best_v)
endmodule

// ===== tb/knn_vote_top_three_tb.sv =====
// Testbench for knn_vote_top_three: loads, clears and queries with random gaps and
// stalls, checked against an in-bench nearest-neighbour vote predictor.
// Depends on kvt_pkg and the knn_vote_top_three RTL.
module knn_vote_top_three_tb;
    import kvt_pkg::*;

    typedef struct {
        logic [CLASS_W-1:0] c1, c2, c3;
        logic [VOTE_W-1:0]  v1, v2, v3;
    } t_vote_result;

    class vote_scoreboard;
        logic [SCORE_W-1:0] scores[MAX_SAMPLES];
        logic [CLASS_W-1:0] classes[MAX_SAMPLES];
        int unsigned        count;
        logic [K_W-1:0]     k;
        t_vote_result       pending[$];
        int                 errors;

        function new();
            count = 0;
            k = K_RESET;
            errors = 0;
        endfunction

        function int best_class(int ex1, int ex2, int votes[NUM_CLASSES]);
            int b;
            b = -1;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                if (c == ex1 || c == ex2) continue;
                if (b < 0 || votes[c] >= votes[b]) b = c;
            end
            return b;
        endfunction

        function void note_word(logic [1:0] op, logic [SCORE_W-1:0] s,
                                logic [CLASS_W-1:0] cl, logic [SCORE_W-1:0] q);
            int votes[NUM_CLASSES];
            bit chosen[MAX_SAMPLES];
            int picks, b, c1, c2, c3;
            longint d, bd, dd;
            t_vote_result r;
            if (op == OP_CLEAR) begin
                count = 0;
            end else if (op == OP_LOAD) begin
                if (count < MAX_SAMPLES) begin
                    scores[count] = s;
                    classes[count] = cl;
                    count++;
                end
            end else if (op == OP_QUERY) begin
                foreach (votes[i]) votes[i] = 0;
                foreach (chosen[i]) chosen[i] = 0;
                picks = (k < count) ? k : count;
                for (int p = 0; p < picks; p++) begin
                    b = -1;
                    bd = 0;
                    for (int i = 0; i < count; i++) begin
                        if (chosen[i]) continue;
                        d = longint'(scores[i]) - longint'(q);
                        dd = d < 0 ? -d : d;
                        if (b < 0 || dd < bd) begin
                            b = i;
                            bd = dd;
                        end
                    end
                    chosen[b] = 1;
                    votes[classes[b]]++;
                end
                c1 = best_class(NUM_CLASSES, NUM_CLASSES, votes);
                c2 = best_class(c1, NUM_CLASSES, votes);
                c3 = best_class(c1, c2, votes);
                r.c1 = CLASS_W'(c1); r.c2 = CLASS_W'(c2); r.c3 = CLASS_W'(c3);
                r.v1 = VOTE_W'(votes[c1]);
                r.v2 = VOTE_W'(votes[c2]);
                r.v3 = VOTE_W'(votes[c3]);
                pending.push_back(r);
            end
        endfunction

        function void check_result(t_vote_result a);
            t_vote_result e;
            if (pending.size() == 0) begin
                $error("unexpected result word");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.c1 !== e.c1) begin
                $error("first_class exp %0d got %0d", e.c1, a.c1); errors++;
            end
            if (a.c2 !== e.c2) begin
                $error("second_class exp %0d got %0d", e.c2, a.c2); errors++;
            end
            if (a.c3 !== e.c3) begin
                $error("third_class exp %0d got %0d", e.c3, a.c3); errors++;
            end
            if (a.v1 !== e.v1) begin
                $error("first_votes exp %0d got %0d", e.v1, a.v1); errors++;
            end
            if (a.v2 !== e.v2) begin
                $error("second_votes exp %0d got %0d", e.v2, a.v2); errors++;
            end
            if (a.v3 !== e.v3) begin
                $error("third_votes exp %0d got %0d", e.v3, a.v3); errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_op;
    logic [SCORE_W-1:0] i_sample_score;
    logic [CLASS_W-1:0] i_sample_class;
    logic [SCORE_W-1:0] i_query_score;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [CLASS_W-1:0] o_first_class, o_second_class, o_third_class;
    logic [VOTE_W-1:0]  o_first_votes, o_second_votes, o_third_votes;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [K_W-1:0]     i_cfg_data;

    vote_scoreboard sb = new();
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    int  quiet_cycles;
    localparam int QUIET_LIMIT = 200000;

    knn_vote_top_three dut (.*);

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;
        i_in_valid = 0;
        i_op = OP_CLEAR;
        i_sample_score = '0;
        i_sample_class = '0;
        i_query_score = '0;
        i_out_stall = 0;
        i_cfg_valid = 0;
        i_cfg_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
    end

    // receiver: random stall, long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 0;
        end else begin
            i_out_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_vote_result r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            r.c1 = o_first_class;  r.c2 = o_second_class; r.c3 = o_third_class;
            r.v1 = o_first_votes;  r.v2 = o_second_votes; r.v3 = o_third_votes;
            sb.check_result(r);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // valid stays high after acceptance; the caller drops it when it stops sending
    task automatic send_word(logic [1:0] op, logic [SCORE_W-1:0] s,
                             logic [CLASS_W-1:0] cl, logic [SCORE_W-1:0] q);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_op <= op;
        i_sample_score <= s;
        i_sample_class <= cl;
        i_query_score <= q;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(op, s, cl, q);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_k(logic [K_W-1:0] kv);
        drain();
        i_cfg_valid <= 1;
        i_cfg_data <= kv;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        sb.k = kv;
    endtask

    task automatic random_word();
        int sel;
        logic [SCORE_W-1:0] base;
        sel = $urandom_range(99);
        base = SCORE_W'($urandom_range(2000));
        if (sel < 3)
            send_word(OP_CLEAR, SCORE_W'($urandom), CLASS_W'($urandom),
                      SCORE_W'($urandom));
        else if (sel < 5)
            send_word(OP_UNUSED, SCORE_W'($urandom), CLASS_W'($urandom),
                      SCORE_W'($urandom));
        else if (sel < 65)
            send_word(OP_LOAD, (sel < 15) ? SCORE_W'($urandom) : base,
                      CLASS_W'($urandom), SCORE_W'($urandom));
        else
            send_word(OP_QUERY, SCORE_W'($urandom), CLASS_W'($urandom),
                      (sel < 75) ? SCORE_W'($urandom) : base);
    endtask

    initial begin
        @(posedge i_clk);
        wait (i_rst_n);
        @(posedge i_clk);
        // directed: empty store, extremes, ties, unused op, clear
        send_word(OP_QUERY, '0, '0, '0);
        send_word(OP_LOAD, '0, '0, '0);
        send_word(OP_LOAD, '1, '1, '1);
        send_word(OP_LOAD, 20'd100, 7'd5, '0);
        send_word(OP_LOAD, 20'd100, 7'd6, '0);
        send_word(OP_LOAD, 20'd90, 7'd5, '0);
        send_word(OP_LOAD, 20'd110, 7'd6, '0);
        send_word(OP_QUERY, '0, '0, 20'd100);
        send_word(OP_QUERY, '0, '0, '1);
        send_word(OP_QUERY, '0, '0, '0);
        send_word(OP_UNUSED, '1, '1, '1);
        send_word(OP_QUERY, '0, '0, 20'h55555);
        write_k(7'd1);
        send_word(OP_QUERY, '0, '0, 20'd100);
        write_k(7'd0);
        send_word(OP_QUERY, '0, '0, 20'd100);
        write_k(7'd127);
        send_word(OP_QUERY, '0, '0, 20'd95);
        send_word(OP_CLEAR, '0, '0, '0);
        send_word(OP_QUERY, '0, '0, 20'd95);
        write_k(7'd64);
        send_word(OP_LOAD, 20'hAAAAA, 7'h2A, '0);
        send_word(OP_QUERY, '0, '0, 20'hAAAAA);

        // sender pauses for a full drain, receiver holds off long
        drain();
        recv_hold = 1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                recv_hold = 0;
            end
            begin
                send_word(OP_QUERY, '0, '0, 20'd5);
                send_word(OP_QUERY, '0, '0, 20'd6);
                send_word(OP_LOAD, 20'd7, 7'd9, '0);
                send_word(OP_QUERY, '0, '0, 20'd7);
                i_in_valid <= 0;
            end
        join

        send_idle_pct = 6;
        recv_idle_pct = 49;
        write_k(7'd3);
        repeat (25) random_word();
        send_idle_pct = 49;
        recv_idle_pct = 6;
        write_k(7'd40);
        repeat (25) random_word();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_k(K_W'($urandom_range(1, 64)));
        repeat (25) random_word();

        drain();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
